// File: hdl/first_fit_region_allocator_defines.svh
// ----------------------------------------------------------------------------
// First-fit region allocator: assertion macros
// Shared helper macros for the concurrent checks in the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// First-fit region allocator package
// Operation and status codes shared by the allocator's files.
// ----------------------------------------------------------------------------
package ffra_pkg;

  typedef logic [1:0] status_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_ALLOC_FAIL = 2'd1;
  localparam status_t ST_FREE_NULL  = 2'd2;
  localparam status_t ST_TABLE_FULL = 2'd3;

endpackage

// File: hdl/ffra_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// First-fit region allocator
// Free-list allocator over a pool of fixed-size units with address-ordered
// free regions and coalescing on release.
// ----------------------------------------------------------------------------
// One transaction on the input channel is one allocate or one free, and it
// always yields exactly one result transaction. The free-region table lives
// in a RAM with a single registered read port, and one small sequencer walks
// it an entry per cycle: the first-fit or address-order scan reads the table
// entries in order, and removing or inserting an entry then moves up to
// region_count entries, again one per cycle. The shortest items are a null
// free and a zero or oversized request, the longest a free inserted into an
// almost full table, and the input is not ready while one is in progress.
// After reset and after each write of pool_units, the sequencer writes the
// single initial region before items are taken again.
// UNIT_BYTES and POOL_UNITS_MAX must be powers of two.
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
  parameter int POOL_UNITS_MAX = 4096,
  parameter int MAX_REGIONS    = 64,
  parameter int UNIT_BYTES     = 16,
  parameter int HEADER_BYTES   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [12:0]      pool_units,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  input  logic [15:0]      request_bytes,
  input  logic [15:0]      release_address,
  output logic             out_valid,
  input  logic             out_ready,
  output ffra_pkg::status_t status,
  output logic [15:0]      granted_address,
  output logic [11:0]      free_units
);

  import ffra_pkg::*;

  `include "first_fit_region_allocator_defines.svh"

  localparam int UW       = $clog2(POOL_UNITS_MAX);
  localparam int PW       = $clog2(POOL_UNITS_MAX + 1);
  localparam int IW       = $clog2(MAX_REGIONS);
  localparam int CW       = $clog2(MAX_REGIONS + 1);
  localparam int EW       = 2 * UW;
  localparam int UB_SHIFT = $clog2(UNIT_BYTES);
  localparam int SUM_MAX  = 65535 + HEADER_BYTES + UNIT_BYTES - 1;
  localparam int SW       = $clog2(SUM_MAX + 1);
  localparam int BW       = $clog2((SUM_MAX >> UB_SHIFT) + 1);
  localparam int RESET_POOL = (POOL_UNITS_MAX < 4096) ? POOL_UNITS_MAX : 4096;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_BLEN   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SHIFT  = 4'd5;
  localparam logic [3:0] S_FIXUP  = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  localparam logic [1:0] POST_NONE   = 2'd0;
  localparam logic [1:0] POST_DEC    = 2'd1;
  localparam logic [1:0] POST_INSERT = 2'd2;

  logic [3:0]    state;
  logic [PW-1:0] pool;
  logic [CW-1:0] region_count;
  logic [UW-1:0] free_total;
  logic          op_free;
  logic [BW-1:0] blk;
  logic [UW-1:0] u_reg;
  logic [UW-1:0] len;
  logic [CW-1:0] scan_rd;
  logic          q_v;
  logic [CW-1:0] q_idx;
  logic          hit_found;
  logic [CW-1:0] hit_idx;
  logic [UW-1:0] hit_start;
  logic [UW-1:0] hit_len;
  logic [UW-1:0] prev_start;
  logic [UW-1:0] prev_len;
  logic [CW-1:0] sh_left;
  logic [CW-1:0] sh_rd;
  logic          sh_up;
  logic [1:0]    post;
  status_t       res_status;
  logic [15:0]   res_addr;

  // Region table RAM: each entry holds {start, length}.
  logic          rg_we;
  logic [IW-1:0] rg_waddr;
  logic [EW-1:0] rg_wdata;
  logic [IW-1:0] rg_raddr;
  logic [EW-1:0] rg_rdata;
  logic [UW-1:0] rd_start;
  logic [UW-1:0] rd_len;

  // Block length RAM, indexed by start unit.
  logic          bl_we;
  logic [UW-1:0] bl_waddr;
  logic [UW-1:0] bl_wdata;
  logic [UW-1:0] bl_rdata;

  logic [SW-1:0] blk_sum;
  logic [BW-1:0] blk_in;
  logic [15:0]   a_off;
  logic [UW-1:0] u_in;
  logic [PW-1:0] pool_clamp;
  logic          hit;

  logic          exact;
  logic [UW-1:0] new_len;
  logic [UW-1:0] alloc_u;
  logic [31:0]   gaddr;
  logic          mprev;
  logic          mnext;
  logic          full;
  logic [UW:0]   ft_sum;
  logic [UW-1:0] ft_sat;

  assign rd_start = rg_rdata[EW-1:UW];
  assign rd_len   = rg_rdata[UW-1:0];

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  // Block size in units, header included, rounded up.
  assign blk_sum = SW'(request_bytes) + SW'(HEADER_BYTES + UNIT_BYTES - 1);
  assign blk_in  = BW'(blk_sum >> UB_SHIFT);

  // Released payload offset to start unit; offsets inside the header map to
  // unit 0 and the unit wraps round the maximum pool size.
  assign a_off = release_address - 16'(HEADER_BYTES);
  assign u_in  = (release_address >= 16'(HEADER_BYTES)) ? UW'(a_off >> UB_SHIFT) : '0;

  always_comb begin
    if (pool_units < 13'd2) begin
      pool_clamp = PW'(2);
    end else if (32'(pool_units) > POOL_UNITS_MAX) begin
      pool_clamp = PW'(POOL_UNITS_MAX);
    end else begin
      pool_clamp = PW'(pool_units);
    end
  end

  // Scan hit: first fit by length for an allocate, first entry above the
  // freed unit for a free.
  assign hit = op_free ? (rd_start > u_reg) : (rd_len >= blk);

  // Allocate decision terms.
  assign exact   = (hit_len == UW'(blk));
  assign new_len = hit_len - UW'(blk);
  assign alloc_u = exact ? hit_start : (hit_start + new_len);
  assign gaddr   = 32'(alloc_u) * UNIT_BYTES + HEADER_BYTES;

  // Free decision terms: does the freed region touch its neighbours?
  assign mprev = (hit_idx != '0) &&
                 (({1'b0, prev_start} + {1'b0, prev_len}) == {1'b0, u_reg});
  assign mnext = hit_found && (({1'b0, u_reg} + {1'b0, len}) == {1'b0, hit_start});
  assign full  = (region_count >= CW'(MAX_REGIONS));
  assign ft_sum = {1'b0, free_total} + {1'b0, len};
  assign ft_sat = (ft_sum > (UW+1)'(POOL_UNITS_MAX - 1)) ? UW'(POOL_UNITS_MAX - 1)
                                                          : ft_sum[UW-1:0];

  // RAM port control.
  always_comb begin
    rg_we    = 1'b0;
    rg_waddr = '0;
    rg_wdata = '0;
    rg_raddr = scan_rd[IW-1:0];
    bl_we    = 1'b0;
    bl_waddr = alloc_u;
    bl_wdata = UW'(blk);
    case (state)
      S_INIT: begin
        rg_we    = 1'b1;
        rg_wdata = {UW'(1), UW'(pool - PW'(1))};
      end
      S_SHIFT: begin
        rg_raddr = sh_rd[IW-1:0];
        if (q_v) begin
          rg_we    = 1'b1;
          rg_waddr = sh_up ? IW'(q_idx - CW'(1)) : IW'(q_idx + CW'(1));
          rg_wdata = rg_rdata;
        end
      end
      S_DECIDE: begin
        if (!op_free) begin
          if (hit_found) begin
            bl_we = 1'b1;
            if (!exact) begin
              rg_we    = 1'b1;
              rg_waddr = hit_idx[IW-1:0];
              rg_wdata = {hit_start, new_len};
            end
          end
        end else if (mprev) begin
          rg_we    = 1'b1;
          rg_waddr = IW'(hit_idx - CW'(1));
          rg_wdata = {prev_start, prev_len + len + (mnext ? hit_len : '0)};
        end else if (mnext) begin
          rg_we    = 1'b1;
          rg_waddr = hit_idx[IW-1:0];
          rg_wdata = {u_reg, hit_len + len};
        end
      end
      S_FIXUP: begin
        rg_we    = 1'b1;
        rg_waddr = hit_idx[IW-1:0];
        rg_wdata = {u_reg, len};
      end
      default: begin
      end
    endcase
  end

  ffra_ram #(.WIDTH(EW), .DEPTH(MAX_REGIONS)) u_region_ram (
    .clk   (clk),
    .we    (rg_we),
    .waddr (rg_waddr),
    .wdata (rg_wdata),
    .raddr (rg_raddr),
    .rdata (rg_rdata)
  );

  ffra_ram #(.WIDTH(UW), .DEPTH(POOL_UNITS_MAX)) u_block_ram (
    .clk   (clk),
    .we    (bl_we),
    .waddr (bl_waddr),
    .wdata (bl_wdata),
    .raddr (u_in),
    .rdata (bl_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      pool         <= PW'(RESET_POOL);
      region_count <= '0;
      free_total   <= '0;
      q_v          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // A result taken while the next one is ready is replaced in S_DONE.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          region_count <= CW'(1);
          free_total   <= UW'(pool - PW'(1));
          state        <= S_IDLE;
        end
        S_IDLE: begin
          scan_rd <= '0;
          q_v     <= 1'b0;
          if (cfg_valid) begin
            pool  <= pool_clamp;
            state <= S_INIT;
          end else if (in_valid) begin
            op_free  <= (func == FUNC_FREE);
            res_addr <= '0;
            if (func == FUNC_ALLOC) begin
              blk <= blk_in;
              if ((request_bytes == '0) || (blk_in > free_total)) begin
                res_status <= ST_ALLOC_FAIL;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              u_reg <= u_in;
              if (release_address == '0) begin
                res_status <= ST_FREE_NULL;
                state      <= S_DONE;
              end else begin
                state <= S_BLEN;
              end
            end
          end
        end
        S_BLEN: begin
          len <= bl_rdata;
          if (bl_rdata == '0) begin
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (q_v && hit) begin
            hit_found <= 1'b1;
            hit_idx   <= q_idx;
            hit_start <= rd_start;
            hit_len   <= rd_len;
            q_v       <= 1'b0;
            state     <= S_DECIDE;
          end else begin
            if (q_v) begin
              prev_start <= rd_start;
              prev_len   <= rd_len;
            end
            if (scan_rd < region_count) begin
              q_v     <= 1'b1;
              q_idx   <= scan_rd;
              scan_rd <= scan_rd + CW'(1);
            end else begin
              q_v <= 1'b0;
              if (!q_v) begin
                hit_found <= 1'b0;
                hit_idx   <= region_count;
                state     <= S_DECIDE;
              end
            end
          end
        end
        S_DECIDE: begin
          q_v <= 1'b0;
          if (!op_free) begin
            if (!hit_found) begin
              res_status <= ST_ALLOC_FAIL;
              state      <= S_DONE;
            end else begin
              free_total <= free_total - UW'(blk);
              res_status <= ST_OK;
              res_addr   <= gaddr[15:0];
              if (exact) begin
                sh_left <= region_count - CW'(1) - hit_idx;
                sh_rd   <= hit_idx + CW'(1);
                sh_up   <= 1'b1;
                post    <= POST_DEC;
                state   <= S_SHIFT;
              end else begin
                state <= S_DONE;
              end
            end
          end else if (!mprev && !mnext && full) begin
            res_status <= ST_TABLE_FULL;
            state      <= S_DONE;
          end else begin
            res_status <= ST_OK;
            free_total <= ft_sat;
            if (mprev && mnext) begin
              sh_left <= region_count - CW'(1) - hit_idx;
              sh_rd   <= hit_idx + CW'(1);
              sh_up   <= 1'b1;
              post    <= POST_DEC;
              state   <= S_SHIFT;
            end else if (mprev || mnext) begin
              state <= S_DONE;
            end else begin
              sh_left <= region_count - hit_idx;
              sh_rd   <= region_count - CW'(1);
              sh_up   <= 1'b0;
              post    <= POST_INSERT;
              state   <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (sh_left != '0) begin
            q_v     <= 1'b1;
            q_idx   <= sh_rd;
            sh_rd   <= sh_up ? (sh_rd + CW'(1)) : (sh_rd - CW'(1));
            sh_left <= sh_left - CW'(1);
          end else begin
            q_v <= 1'b0;
            if (!q_v) begin
              case (post)
                POST_DEC: begin
                  region_count <= region_count - CW'(1);
                  state        <= S_DONE;
                end
                POST_INSERT: begin
                  state <= S_FIXUP;
                end
                default: begin
                  state <= S_DONE;
                end
              endcase
            end
          end
        end
        S_FIXUP: begin
          region_count <= region_count + CW'(1);
          state        <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status          <= res_status;
            granted_address <= res_addr;
            free_units      <= 12'(free_total);
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more regions than it has room for.
  `FFRA_ASSERT_NOW(a_count_bound, 1'b1, region_count <= CW'(MAX_REGIONS), "region count overflow")
  // Once a transaction is taken, the input stays closed while it is worked on.
  `FFRA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready during work")
  // A failed allocate never reports an address.
  `FFRA_ASSERT_NOW(a_fail_no_addr, out_valid && (status == ST_ALLOC_FAIL),
    granted_address == '0, "failed allocate carries an address")
  // A pool write always leads to reinitialisation of the table.
  `FFRA_ASSERT_NEXT(a_cfg_reinit, cfg_valid && cfg_ready, state == S_INIT, "pool write not applied")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// First-fit region allocator testbench
// Drives allocate and free transactions with random idling on both channels,
// predicts every result with a behavioural model of the free-region table and
// compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffra_pkg::*;

  localparam int POOL_MAX   = 4096;
  localparam int MAX_REG    = 64;
  localparam int UNIT_B     = 16;
  localparam int HDR_B      = 8;
  localparam int CYCLE_MAX  = 1500000;

  typedef struct packed {
    logic        op;
    logic [15:0] req;
    logic [15:0] addr;
  } alloc_req_t;

  typedef struct packed {
    status_t     st;
    logic [15:0] grant;
    logic [11:0] units;
  } alloc_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] pool_units = 13'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_ALLOC;
  logic [15:0] request_bytes = '0;
  logic [15:0] release_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  status_t     status;
  logic [15:0] granted_address;
  logic [11:0] free_units;

  first_fit_region_allocator u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pool_units(pool_units),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .request_bytes(request_bytes), .release_address(release_address),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .granted_address(granted_address), .free_units(free_units)
  );

  always #5 clk = ~clk;

  // Predictor state: a private copy of the free-region table.
  int unsigned pred_pool;
  int unsigned reg_start [MAX_REG];
  int unsigned reg_len [MAX_REG];
  int unsigned reg_cnt;
  int unsigned free_tot;
  int unsigned blk_len [POOL_MAX];
  bit          blk_seen [POOL_MAX];

  alloc_req_t  pending_q [$];
  alloc_resp_t expected_q [$];

  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;              // no idling in the last part of the run
  int  in_gap = 0;
  int  out_gap = 0;
  int  cfg_word = -1;             // -1 means no write pending
  bit  timed_out = 1'b0;

  // Handshake flags raised by the monitor for the driver's next falling edge.
  bit in_accepted = 1'b0;
  bit cfg_accepted = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %0s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic void table_init();
    for (int k = 0; k < MAX_REG; k++) begin
      reg_start[k] = 0;
      reg_len[k] = 0;
    end
    reg_start[0] = 1;
    reg_len[0] = pred_pool - 1;
    reg_cnt = 1;
    free_tot = pred_pool - 1;
  endfunction

  function automatic void table_remove(int unsigned idx);
    for (int unsigned k = idx; k + 1 < reg_cnt; k++) begin
      reg_start[k] = reg_start[k + 1];
      reg_len[k] = reg_len[k + 1];
    end
    reg_cnt--;
    reg_start[reg_cnt] = 0;
    reg_len[reg_cnt] = 0;
  endfunction

  // Computes the result of one transaction and updates the table copy.
  function automatic alloc_resp_t predict_alloc(alloc_req_t it);
    alloc_resp_t r;
    int unsigned blk, i, u, len, tot;
    bit prv, nxt;
    r.st = ST_ALLOC_FAIL;
    r.grant = '0;
    if (it.op == FUNC_ALLOC) begin
      if (it.req != 0) begin
        blk = (it.req + HDR_B + UNIT_B - 1) / UNIT_B;
        if (blk <= free_tot) begin
          for (i = 0; i < reg_cnt; i++)
            if (reg_len[i] >= blk) break;
          if (i < reg_cnt) begin
            if (reg_len[i] == blk) begin
              u = reg_start[i];
              table_remove(i);
            end else begin
              reg_len[i] -= blk;
              u = reg_start[i] + reg_len[i];
            end
            u = u % POOL_MAX;
            blk_len[u] = blk;
            blk_seen[u] = 1'b1;
            free_tot -= blk;
            r.st = ST_OK;
            r.grant = 16'((u * UNIT_B + HDR_B) & 16'hFFFF);
          end
        end
      end
    end else if (it.addr == 0) begin
      r.st = ST_FREE_NULL;
    end else begin
      r.st = ST_OK;
      u = (it.addr >= HDR_B) ? (it.addr - HDR_B) / UNIT_B : 0;
      u = u % POOL_MAX;
      len = blk_len[u];
      if (len != 0) begin
        for (i = 0; i < reg_cnt; i++)
          if (reg_start[i] > u) break;
        prv = (i > 0) && (reg_start[i - 1] + reg_len[i - 1] == u);
        nxt = (i < reg_cnt) && (u + len == reg_start[i]);
        if (!prv && !nxt && reg_cnt >= MAX_REG) begin
          r.st = ST_TABLE_FULL;
        end else begin
          if (prv) begin
            reg_len[i - 1] += len;
            if (nxt) begin
              reg_len[i - 1] += reg_len[i];
              table_remove(i);
            end
          end else if (nxt) begin
            reg_start[i] = u;
            reg_len[i] += len;
          end else begin
            for (int unsigned k = reg_cnt; k > i; k--) begin
              reg_start[k] = reg_start[k - 1];
              reg_len[k] = reg_len[k - 1];
            end
            reg_start[i] = u;
            reg_len[i] = len;
            reg_cnt++;
          end
          tot = free_tot + len;
          free_tot = (tot > POOL_MAX - 1) ? POOL_MAX - 1 : tot;
        end
      end
    end
    r.units = 12'(free_tot);
    return r;
  endfunction

  // Stimulus helpers: in the random phases, apart from the null address, only
  // addresses whose unit has a recorded length are freed.
  function automatic bit addr_ok(int unsigned a);
    int unsigned u;
    if (a == 0) return 1'b1;
    u = ((a >= HDR_B) ? (a - HDR_B) / UNIT_B : 0) % POOL_MAX;
    return blk_seen[u];
  endfunction

  function automatic void push_alloc(int unsigned bytes);
    alloc_req_t it;
    it.op = FUNC_ALLOC;
    it.req = 16'(bytes);
    it.addr = 16'($urandom);
    pending_q.push_back(it);
  endfunction

  function automatic void push_free(int unsigned a);
    alloc_req_t it;
    it.op = FUNC_FREE;
    it.req = 16'($urandom);
    it.addr = 16'(a);
    pending_q.push_back(it);
  endfunction

  // Driver: one transaction at a time from the pending queue, changed at the
  // falling edge so that the block sees stable inputs at the rising edge.
  always @(negedge clk) begin
    if (!rst) begin
      if ((!in_valid || in_accepted) && pending_q.size() > 0 && cfg_word < 0) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(7) == 0) begin
          in_gap = $urandom_range(16, 1) - 1;
          in_valid <= 1'b0;
        end else begin
          alloc_req_t it;
          it = pending_q.pop_front();
          in_valid <= 1'b1;
          func <= it.op;
          request_bytes <= it.req;
          release_address <= it.addr;
        end
      end else if (in_valid && in_accepted) begin
        in_valid <= 1'b0;
      end
      // Result side stalls in bursts as well.
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(7) == 0) begin
        out_gap = $urandom_range(16, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if (cfg_valid && cfg_accepted) cfg_valid <= 1'b0;
      else if (!cfg_valid && cfg_word >= 0 && !in_valid) begin
        cfg_valid <= 1'b1;
        pool_units <= 13'(cfg_word);
      end
    end
  end

  // Monitor: handshakes sampled at the rising edge. Predictions are made on
  // acceptance, so the expectation queue always follows the block's order.
  always @(posedge clk) begin
    alloc_req_t  it;
    alloc_resp_t want;
    cycles++;
    in_accepted <= !rst && in_valid && in_ready;
    cfg_accepted <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        it.op = func;
        it.req = request_bytes;
        it.addr = release_address;
        expected_q.push_back(predict_alloc(it));
      end
      if (cfg_valid && cfg_ready) begin
        pred_pool = (pool_units < 2) ? 2 : ((pool_units > POOL_MAX) ? POOL_MAX : pool_units);
        table_init();
        cfg_word = -1;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", status, -1);
        end else begin
          want = expected_q.pop_front();
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (granted_address !== want.grant)
            report_mismatch("granted_address", granted_address, want.grant);
          if (free_units !== want.units)
            report_mismatch("free_units", free_units, want.units);
        end
      end
    end
    if (cycles >= CYCLE_MAX) timed_out = 1'b1;
  end

  task automatic wait_drained();
    while ((pending_q.size() > 0 || in_valid || expected_q.size() > 0) && !timed_out)
      @(posedge clk);
    // An item in flight has always produced its result, but leave the
    // sequencer time to settle before touching the register.
    repeat (2 * MAX_REG + 10) @(posedge clk);
  endtask

  task automatic write_pool(int unsigned v);
    cfg_word = v;
    while (cfg_word >= 0 && !timed_out) @(posedge clk);
    @(posedge clk);
  endtask

  // The model's grants are only known on acceptance, so the stimulus reads
  // the predictor's record of written lengths through blk_seen. A free is
  // generated just before it is needed by waiting for the queue to drain a
  // little, which keeps the target set current.
  task automatic run_phase(int n, int unsigned max_bytes, int free_pct);
    int unsigned a, tries;
    for (int k = 0; k < n && !timed_out; k++) begin
      while (pending_q.size() > 2 && !timed_out) @(posedge clk);
      if ($urandom_range(99) < free_pct) begin
        tries = 0;
        do begin
          a = (($urandom_range(19) == 0) ? 0 :
               ($urandom_range(pred_pool - 1) * UNIT_B + HDR_B + $urandom_range(15)));
          a = a & 16'hFFFF;
          tries++;
        end while (!addr_ok(a) && tries < 64);
        if (!addr_ok(a)) a = 0;
        push_free(a);
      end else begin
        push_alloc($urandom_range(max_bytes));
      end
    end
  endtask

  initial begin
    for (int k = 0; k < POOL_MAX; k++) begin
      blk_len[k] = 0;
      blk_seen[k] = 1'b0;
    end
    pred_pool = 4096;
    table_init();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: zero request, field extremes, null free, misaligned
    // frees and a repeated free.
    push_alloc(0);
    push_alloc(16'hFFFF);
    push_alloc(1);
    push_alloc(8);
    push_alloc(9);
    push_alloc(24);
    push_alloc(65520 - 8 - 16 * 300);
    push_free(0);
    wait_drained();
    for (int k = 0; k < 6; k++) begin
      int unsigned a;
      a = 0;
      for (int u = pred_pool - 1; u > 0; u--)
        if (blk_seen[u]) begin a = u * UNIT_B + HDR_B + k; break; end
      push_free(a);
      wait_drained();
    end
    push_free(16'hFFFF);
    wait_drained();

    // Several pool sizes, extremes among them; some work in small pools so
    // the table fills and merges often.
    write_pool(2);
    run_phase(40, 40, 40);
    wait_drained();
    write_pool(0);
    run_phase(20, 20, 40);
    wait_drained();
    write_pool(13'h1FFF);
    run_phase(300, 700, 45);
    wait_drained();
    write_pool(200);
    // Fill the table with many one-unit blocks, then free every other one
    // to push the region count to its limit.
    for (int k = 0; k < 199 && !timed_out; k++) push_alloc($urandom_range(8, 1));
    wait_drained();
    for (int u = 2; u < 200 && !timed_out; u += 2) begin
      while (pending_q.size() > 2) @(posedge clk);
      if (blk_seen[u]) push_free(u * UNIT_B + HDR_B);
    end
    wait_drained();
    write_pool(1000);
    run_phase(500, 200, 45);
    wait_drained();
    write_pool(4096);
    run_phase(400, 2000, 48);
    wait_drained();
    write_pool($urandom_range(4095, 3));
    quiet = 1'b1;
    run_phase(300, 300, 45);
    wait_drained();

    if (timed_out) $display("tb_top failed");
    else if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("timeout after %0d cycles", cycles);
    $display("tb_top failed");
    $finish;
  end

endmodule
